// ===== rtl/rah_pkg.sv =====
// ----------------------------------------------------------------------------
// rah_pkg
// Shared types and constants of the region access histogram.
// ----------------------------------------------------------------------------
package rah_pkg;

    localparam int ADDR_W     = 48;
    localparam int CNT_W      = 32;
    localparam int MAX_REG    = 16;
    localparam int REG_W      = 4;
    localparam int USED_W     = 5;
    localparam int OBJ_W      = 8;
    localparam int NOBJ_W     = 9;
    localparam int OSZ_W      = 16;
    localparam int MEM_AW     = REG_W + OBJ_W;
    localparam int STAT_W     = 3;
    localparam int KCNT_W     = 4;

    localparam logic [OSZ_W-1:0] OBJ_SIZE_RESET = 16'd1536;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_ACCESS = 2'd2;
    localparam logic [1:0] ACT_READ   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STAT_W-1:0] ST_TOO_LARGE = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_OUTSIDE   = 3'd4;
    localparam logic [STAT_W-1:0] ST_BAD_INDEX = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_CHK,
        S_INS_DIV,
        S_CLEAR,
        S_REMOVE,
        S_SEARCH,
        S_ACC_DIV,
        S_ACC_RD,
        S_READ,
        S_RD_WAIT,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] size;
        logic [NOBJ_W-1:0] nobj;
        logic [OSZ_W-1:0]  obj;
        logic [REG_W-1:0]  slot;
    } t_entry;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [REG_W-1:0]  region;
        logic [OBJ_W-1:0]  object;
        logic [CNT_W-1:0]  count;
    } t_result;

    typedef struct packed {
        logic              we;
        logic [MEM_AW-1:0] addr;
        logic [CNT_W-1:0]  wdata;
    } t_mem_req;

endpackage

// ===== rtl/rah_divider.sv =====
// ----------------------------------------------------------------------------
// rah_divider
// Restoring divider, one quotient bit per cycle, quotient below 512.
// ----------------------------------------------------------------------------
module rah_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rah_pkg::ADDR_W-1:0] i_dividend,
    input  logic [rah_pkg::OSZ_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [rah_pkg::NOBJ_W-1:0] o_quot,
    output logic                       o_rem_nz
);

    logic                        r_busy;
    logic                        r_done;
    logic [rah_pkg::KCNT_W-1:0]  r_k;
    logic [rah_pkg::ADDR_W-1:0]  r_rem;
    logic [rah_pkg::OSZ_W-1:0]   r_div;
    logic [rah_pkg::NOBJ_W-1:0]  r_q;
    logic [rah_pkg::ADDR_W-1:0]  trial;
    logic                        ge;

    assign trial = rah_pkg::ADDR_W'(r_div) << r_k;
    assign ge    = (r_rem >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_k == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_div <= i_divisor;
            r_k   <= rah_pkg::KCNT_W'(rah_pkg::NOBJ_W - 1);
            r_q   <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[rah_pkg::NOBJ_W-2:0], ge};
            r_rem <= ge ? r_rem - trial : r_rem;
            r_k   <= r_k - 1'b1;
        end
    end

    assign o_done   = r_done;
    assign o_quot   = r_q;
    assign o_rem_nz = |r_rem;

endmodule

// ===== rtl/rah_count_ram.sv =====
// ----------------------------------------------------------------------------
// rah_count_ram
// Single-port counter memory, one slot of objects per region.
// ----------------------------------------------------------------------------
module rah_count_ram (
    input  logic                      i_clk,
    input  rah_pkg::t_mem_req         i_req,
    output logic [rah_pkg::CNT_W-1:0] o_rdata
);

    logic [rah_pkg::CNT_W-1:0] r_mem [0:(1 << rah_pkg::MEM_AW)-1];
    logic [rah_pkg::CNT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/region_access_histogram.sv =====
// ----------------------------------------------------------------------------
// region_access_histogram
// Sorted region table with a per-object access counter histogram.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry one command word (insert, remove,
// access, read). Output channel: o_valid / i_stall carry one result word per
// command. Configuration: i_cfg_we writes the object size, which the user
// must do only while idle; the block does not enforce it. One command is in
// flight at a time; o_stall is high while it is worked on. Steps to result:
// remove passes S_REMOVE; read S_READ, then S_RD_WAIT if the index is valid;
// access up to 5 search steps, divider, then a counter update (a miss ends at
// the search); insert a check state (a failure ends there), the divider, then
// the counter slot is cleared one word per cycle through the single port.
// The result sits in an output register; the next command is accepted
// while it waits. A stalled result holds and blocks only the next result.
// Reset (synchronous, active low) empties the table, frees all slots and
// loads the object size 1536. Counter memory needs no clearing pass.
// ----------------------------------------------------------------------------
module region_access_histogram (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [1:0]                          i_action,
    input  logic [rah_pkg::ADDR_W-1:0]          i_region_start,
    input  logic [rah_pkg::ADDR_W-1:0]          i_region_size,
    input  logic [rah_pkg::ADDR_W-1:0]          i_address,
    input  logic [rah_pkg::REG_W-1:0]           i_read_region,
    input  logic [rah_pkg::OBJ_W-1:0]           i_read_object,
    input  logic                                i_cfg_we,
    input  logic [rah_pkg::OSZ_W-1:0]           i_cfg_data,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [rah_pkg::STAT_W-1:0]          o_status,
    output logic [rah_pkg::REG_W-1:0]           o_region_index,
    output logic [rah_pkg::OBJ_W-1:0]           o_object_index,
    output logic [rah_pkg::CNT_W-1:0]           o_count_value
);

    rah_pkg::t_state  r_state, n_state;
    rah_pkg::t_entry  r_tab [0:rah_pkg::MAX_REG-1];
    rah_pkg::t_result r_res, r_out;
    rah_pkg::t_mem_req mem_req;

    logic                          r_o_valid;
    logic [rah_pkg::OSZ_W-1:0]     r_obj;
    logic [1:0]                    r_act;
    logic [rah_pkg::ADDR_W-1:0]    r_start, r_size, r_addr;
    logic [rah_pkg::REG_W-1:0]     r_rreg;
    logic [rah_pkg::OBJ_W-1:0]     r_robj;
    logic [rah_pkg::USED_W-1:0]    r_used;
    logic [rah_pkg::MAX_REG-1:0]   r_busy;
    logic [rah_pkg::USED_W-1:0]    r_lo, r_hi;
    logic [rah_pkg::REG_W-1:0]     r_mid, r_slot, r_pos;
    logic [rah_pkg::OBJ_W-1:0]     r_clr;
    logic [rah_pkg::MEM_AW-1:0]    r_maddr;

    logic                          accept;
    logic [rah_pkg::OSZ_W-1:0]     obj_eff;
    logic                          too_large;
    logic                          slot_found;
    logic [rah_pkg::REG_W-1:0]     free_slot;
    logic [rah_pkg::USED_W-1:0]    ins_pos;
    logic                          rm_found;
    logic [rah_pkg::REG_W-1:0]     rm_idx;
    logic [rah_pkg::USED_W:0]      mid_sum;
    logic [rah_pkg::REG_W-1:0]     mid;
    rah_pkg::t_entry               e_mid;
    logic [rah_pkg::ADDR_W-1:0]    offset;
    logic                          contains, below;
    logic                          rd_ok;
    logic                          acc_in;
    logic                          out_free;
    logic [rah_pkg::CNT_W-1:0]     cnt_rd, cnt_inc;

    logic                          div_start, div_done, div_rem_nz;
    logic [rah_pkg::ADDR_W-1:0]    div_dividend;
    logic [rah_pkg::OSZ_W-1:0]     div_divisor;
    logic [rah_pkg::NOBJ_W-1:0]    div_quot;

    assign accept   = i_valid && (r_state == rah_pkg::S_IDLE);
    assign obj_eff  = (r_obj == '0) ? rah_pkg::OSZ_W'(1) : r_obj;
    assign too_large = r_size > (rah_pkg::ADDR_W'(obj_eff) << rah_pkg::OBJ_W);
    assign out_free = !r_o_valid || !i_stall;

    always_comb begin
        slot_found = 1'b0;
        free_slot  = '0;
        for (int i = rah_pkg::MAX_REG - 1; i >= 0; i--) begin
            if (!r_busy[i]) begin
                slot_found = 1'b1;
                free_slot  = rah_pkg::REG_W'(i);
            end
        end
    end

    always_comb begin
        ins_pos  = '0;
        rm_found = 1'b0;
        rm_idx   = '0;
        for (int i = 0; i < rah_pkg::MAX_REG; i++) begin
            if (rah_pkg::USED_W'(i) < r_used && r_tab[i].start <= r_start) begin
                ins_pos = ins_pos + 1'b1;
            end
        end
        for (int i = rah_pkg::MAX_REG - 1; i >= 0; i--) begin
            if (rah_pkg::USED_W'(i) < r_used && r_tab[i].start == r_start) begin
                rm_found = 1'b1;
                rm_idx   = rah_pkg::REG_W'(i);
            end
        end
    end

    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid      = mid_sum[rah_pkg::REG_W:1];
    assign e_mid    = r_tab[mid];
    assign offset   = r_addr - e_mid.start;
    assign below    = r_addr < e_mid.start;
    assign contains = !below && (offset < e_mid.size);
    assign rd_ok    = ({1'b0, r_rreg} < r_used) &&
                      ({1'b0, r_robj} < r_tab[r_rreg].nobj);
    assign acc_in   = div_quot < r_tab[r_mid].nobj;
    assign cnt_inc  = (&cnt_rd) ? cnt_rd : cnt_rd + 1'b1;

    rah_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem_nz   (div_rem_nz)
    );

    rah_count_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (cnt_rd)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            rah_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_action)
                        rah_pkg::ACT_INSERT: n_state = rah_pkg::S_INS_CHK;
                        rah_pkg::ACT_REMOVE: n_state = rah_pkg::S_REMOVE;
                        rah_pkg::ACT_ACCESS: n_state = rah_pkg::S_SEARCH;
                        default:             n_state = rah_pkg::S_READ;
                    endcase
                end
            end
            rah_pkg::S_INS_CHK: begin
                if (r_used >= rah_pkg::USED_W'(rah_pkg::MAX_REG) || too_large || !slot_found) begin
                    n_state = rah_pkg::S_RESULT;
                end else begin
                    n_state = rah_pkg::S_INS_DIV;
                end
            end
            rah_pkg::S_INS_DIV: if (div_done) n_state = rah_pkg::S_CLEAR;
            rah_pkg::S_CLEAR:   if (&r_clr) n_state = rah_pkg::S_RESULT;
            rah_pkg::S_REMOVE:  n_state = rah_pkg::S_RESULT;
            rah_pkg::S_SEARCH: begin
                if (r_lo >= r_hi) begin
                    n_state = rah_pkg::S_RESULT;
                end else if (contains) begin
                    n_state = rah_pkg::S_ACC_DIV;
                end
            end
            rah_pkg::S_ACC_DIV: begin
                if (div_done) n_state = acc_in ? rah_pkg::S_ACC_RD : rah_pkg::S_RESULT;
            end
            rah_pkg::S_ACC_RD:  n_state = rah_pkg::S_RESULT;
            rah_pkg::S_READ:    n_state = rd_ok ? rah_pkg::S_RD_WAIT : rah_pkg::S_RESULT;
            rah_pkg::S_RD_WAIT: n_state = rah_pkg::S_RESULT;
            rah_pkg::S_RESULT:  if (out_free) n_state = rah_pkg::S_IDLE;
            default:            n_state = rah_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        div_start     = 1'b0;
        div_dividend  = r_size;
        div_divisor   = obj_eff;
        mem_req.we    = 1'b0;
        mem_req.addr  = r_maddr;
        mem_req.wdata = '0;
        case (r_state)
            rah_pkg::S_INS_CHK: begin
                div_start = (n_state == rah_pkg::S_INS_DIV);
            end
            rah_pkg::S_SEARCH: begin
                div_start    = (r_lo < r_hi) && contains;
                div_dividend = offset;
                div_divisor  = e_mid.obj;
            end
            rah_pkg::S_CLEAR: begin
                mem_req.we   = 1'b1;
                mem_req.addr = {r_slot, r_clr};
            end
            rah_pkg::S_ACC_DIV: begin
                mem_req.addr = {r_tab[r_mid].slot, div_quot[rah_pkg::OBJ_W-1:0]};
            end
            rah_pkg::S_ACC_RD: begin
                mem_req.we    = 1'b1;
                mem_req.wdata = cnt_inc;
            end
            rah_pkg::S_READ: begin
                mem_req.addr = {r_tab[r_rreg].slot, r_robj};
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    assign o_stall = (r_state != rah_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rah_pkg::S_IDLE;
            r_obj     <= rah_pkg::OBJ_SIZE_RESET;
            r_used    <= '0;
            r_busy    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_obj <= i_cfg_data;
            if (r_state == rah_pkg::S_RESULT && out_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            if (r_state == rah_pkg::S_INS_DIV && div_done) begin
                r_busy[r_slot] <= 1'b1;
                r_used         <= r_used + 1'b1;
            end
            if (r_state == rah_pkg::S_REMOVE && rm_found) begin
                r_busy[r_tab[rm_idx].slot] <= 1'b0;
                r_used                     <= r_used - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act   <= i_action;
            r_start <= i_region_start;
            r_size  <= i_region_size;
            r_addr  <= i_address;
            r_rreg  <= i_read_region;
            r_robj  <= i_read_object;
            r_lo    <= '0;
            r_hi    <= r_used;
        end
        if (r_state == rah_pkg::S_RESULT && out_free) begin
            r_out <= r_res;
        end
        case (r_state)
            rah_pkg::S_INS_CHK: begin
                r_slot <= free_slot;
                r_clr  <= '0;
                r_res  <= '{(r_used < rah_pkg::USED_W'(rah_pkg::MAX_REG) && too_large) ?
                            rah_pkg::ST_TOO_LARGE : rah_pkg::ST_FULL, '0, '0, '0};
            end
            rah_pkg::S_INS_DIV: begin
                if (div_done) begin
                    r_pos <= ins_pos[rah_pkg::REG_W-1:0];
                    for (int i = 1; i < rah_pkg::MAX_REG; i++) begin
                        if (rah_pkg::USED_W'(i) > ins_pos && rah_pkg::USED_W'(i) <= r_used) begin
                            r_tab[i] <= r_tab[i-1];
                        end
                    end
                    r_tab[ins_pos[rah_pkg::REG_W-1:0]] <= '{r_start, r_size,
                        div_quot + rah_pkg::NOBJ_W'(div_rem_nz), obj_eff, r_slot};
                end
            end
            rah_pkg::S_CLEAR: begin
                r_clr <= r_clr + 1'b1;
                r_res <= '{rah_pkg::ST_OK, r_pos, '0, '0};
            end
            rah_pkg::S_REMOVE: begin
                if (rm_found) begin
                    for (int i = 0; i < rah_pkg::MAX_REG - 1; i++) begin
                        if (rah_pkg::REG_W'(i) >= rm_idx &&
                            rah_pkg::USED_W'(i + 1) < r_used) begin
                            r_tab[i] <= r_tab[i+1];
                        end
                    end
                    r_res <= '{rah_pkg::ST_OK, rm_idx, '0, '0};
                end else begin
                    r_res <= '{rah_pkg::ST_NOT_FOUND, '0, '0, '0};
                end
            end
            rah_pkg::S_SEARCH: begin
                r_mid <= mid;
                r_res <= '{rah_pkg::ST_NOT_FOUND, '0, '0, '0};
                if (below) begin
                    r_hi <= rah_pkg::USED_W'(mid);
                end else begin
                    r_lo <= rah_pkg::USED_W'(mid) + 1'b1;
                end
            end
            rah_pkg::S_ACC_DIV: begin
                r_maddr <= mem_req.addr;
                r_res   <= '{rah_pkg::ST_OUTSIDE, r_mid, div_quot[rah_pkg::OBJ_W-1:0], '0};
            end
            rah_pkg::S_ACC_RD: begin
                r_res <= '{rah_pkg::ST_OK, r_res.region, r_res.object, cnt_inc};
            end
            rah_pkg::S_READ: begin
                r_res <= '{rah_pkg::ST_BAD_INDEX, r_rreg, r_robj, '0};
            end
            rah_pkg::S_RD_WAIT: begin
                r_res <= '{rah_pkg::ST_OK, r_rreg, r_robj, cnt_rd};
            end
            default: begin
                r_clr <= r_clr;
            end
        endcase
    end

    assign o_valid        = r_o_valid;
    assign o_status       = r_out.status;
    assign o_region_index = r_out.region;
    assign o_object_index = r_out.object;
    assign o_count_value  = r_out.count;

`ifndef NO_ASSERTIONS
    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= rah_pkg::USED_W'(rah_pkg::MAX_REG))
        else $error("region count above capacity");

    a_slots_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_busy) == 32'(r_used))
        else $error("busy slots differ from region count");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state != rah_pkg::S_IDLE)
        else $error("accepted word not processed");

    a_act_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rah_pkg::S_REMOVE |-> r_act == rah_pkg::ACT_REMOVE)
        else $error("remove state entered for another command");
`endif

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the region access histogram. A directed table
// covers reset, the field extremes and the too large, not found and bad
// index statuses; random phases at several object sizes follow. Results are
// checked against typed rows or a predictor of the sorted table and counters.
// ----------------------------------------------------------------------------
module tb;

    localparam int LIMIT        = 3000000;
    localparam int RAND_ITEMS   = 1400;
    localparam int PHASES       = 6;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 600;

    typedef struct {
        logic [1:0]                 action;
        logic [rah_pkg::ADDR_W-1:0] start;
        logic [rah_pkg::ADDR_W-1:0] size;
        logic [rah_pkg::ADDR_W-1:0] addr;
        logic [rah_pkg::REG_W-1:0]  rreg;
        logic [rah_pkg::OBJ_W-1:0]  robj;
    } t_cmd;

    typedef struct {
        t_cmd             cmd;
        bit               typed;
        rah_pkg::t_result res;
    } t_row;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_stall;
    logic [1:0]                 i_action = rah_pkg::ACT_INSERT;
    logic [rah_pkg::ADDR_W-1:0] i_region_start = '0;
    logic [rah_pkg::ADDR_W-1:0] i_region_size = '0;
    logic [rah_pkg::ADDR_W-1:0] i_address = '0;
    logic [rah_pkg::REG_W-1:0]  i_read_region = '0;
    logic [rah_pkg::OBJ_W-1:0]  i_read_object = '0;
    logic                       i_cfg_we = 1'b0;
    logic [rah_pkg::OSZ_W-1:0]  i_cfg_data = '0;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic [rah_pkg::STAT_W-1:0] o_status;
    logic [rah_pkg::REG_W-1:0]  o_region_index;
    logic [rah_pkg::OBJ_W-1:0]  o_object_index;
    logic [rah_pkg::CNT_W-1:0]  o_count_value;

    region_access_histogram dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_region_start (i_region_start),
        .i_region_size  (i_region_size),
        .i_address      (i_address),
        .i_read_region  (i_read_region),
        .i_read_object  (i_read_object),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_region_index (o_region_index),
        .o_object_index (o_object_index),
        .o_count_value  (o_count_value)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // table model
    logic [rah_pkg::OSZ_W-1:0]  obj_size_reg;
    logic [rah_pkg::ADDR_W-1:0] tbl_start [rah_pkg::MAX_REG];
    logic [rah_pkg::ADDR_W-1:0] tbl_size  [rah_pkg::MAX_REG];
    logic [rah_pkg::NOBJ_W:0]   tbl_nobj  [rah_pkg::MAX_REG];
    logic [rah_pkg::OSZ_W-1:0]  tbl_objb  [rah_pkg::MAX_REG];
    logic [rah_pkg::REG_W-1:0]  tbl_slot  [rah_pkg::MAX_REG];
    int                         tbl_used;
    bit                         slot_busy [rah_pkg::MAX_REG];
    logic [rah_pkg::CNT_W-1:0]  hist [rah_pkg::MAX_REG][256];

    rah_pkg::t_result           pending_results [$];
    int                         fails = 0;
    int                         cycles = 0;
    int                         results_seen = 0;
    int                         rx_taken = 0;
    int                         status_seen [8];
    bit                         quiet = 1'b0;
    int                         rx_wait = 0;
    logic [rah_pkg::ADDR_W-1:0] start_pool [16];

    function automatic rah_pkg::t_result mk(logic [rah_pkg::STAT_W-1:0] st,
                                            logic [rah_pkg::REG_W-1:0] r,
                                            logic [rah_pkg::OBJ_W-1:0] o,
                                            logic [rah_pkg::CNT_W-1:0] c);
        rah_pkg::t_result x;
        x.status = st;
        x.region = r;
        x.object = o;
        x.count  = c;
        return x;
    endfunction

    function automatic rah_pkg::t_result histogram_step(t_cmd c);
        logic [rah_pkg::ADDR_W:0]   nobj;
        logic [rah_pkg::OSZ_W-1:0]  ob;
        logic [rah_pkg::ADDR_W-1:0] off;
        logic [rah_pkg::ADDR_W-1:0] oi;
        int                         slot, pos, lo, hi, mid;
        slot = 0;
        pos = 0;
        case (c.action)
            rah_pkg::ACT_INSERT: begin
                ob = (obj_size_reg == '0) ? 16'd1 : obj_size_reg;
                if (tbl_used >= rah_pkg::MAX_REG) return mk(rah_pkg::ST_FULL, '0, '0, '0);
                nobj = c.size / ob + ((c.size % ob) != 0);
                if (nobj > 256) return mk(rah_pkg::ST_TOO_LARGE, '0, '0, '0);
                while (slot < rah_pkg::MAX_REG && slot_busy[slot]) slot++;
                while (pos < tbl_used && tbl_start[pos] <= c.start) pos++;
                for (int i = tbl_used; i > pos; i--) begin
                    tbl_start[i] = tbl_start[i-1];
                    tbl_size[i]  = tbl_size[i-1];
                    tbl_nobj[i]  = tbl_nobj[i-1];
                    tbl_objb[i]  = tbl_objb[i-1];
                    tbl_slot[i]  = tbl_slot[i-1];
                end
                tbl_start[pos] = c.start;
                tbl_size[pos]  = c.size;
                tbl_nobj[pos]  = nobj[rah_pkg::NOBJ_W:0];
                tbl_objb[pos]  = ob;
                tbl_slot[pos]  = slot[rah_pkg::REG_W-1:0];
                slot_busy[slot] = 1'b1;
                for (int k = 0; k < 256; k++) hist[slot][k] = '0;
                tbl_used++;
                return mk(rah_pkg::ST_OK, pos[rah_pkg::REG_W-1:0], '0, '0);
            end
            rah_pkg::ACT_REMOVE: begin
                for (int i = 0; i < tbl_used; i++) begin
                    if (tbl_start[i] == c.start) begin
                        slot_busy[tbl_slot[i]] = 1'b0;
                        for (int j = i; j + 1 < tbl_used; j++) begin
                            tbl_start[j] = tbl_start[j+1];
                            tbl_size[j]  = tbl_size[j+1];
                            tbl_nobj[j]  = tbl_nobj[j+1];
                            tbl_objb[j]  = tbl_objb[j+1];
                            tbl_slot[j]  = tbl_slot[j+1];
                        end
                        tbl_used--;
                        return mk(rah_pkg::ST_OK, i[rah_pkg::REG_W-1:0], '0, '0);
                    end
                end
                return mk(rah_pkg::ST_NOT_FOUND, '0, '0, '0);
            end
            rah_pkg::ACT_ACCESS: begin
                lo = 0;
                hi = tbl_used;
                while (lo < hi) begin
                    mid = (lo + hi) / 2;
                    off = c.addr - tbl_start[mid];
                    if (c.addr >= tbl_start[mid] && off < tbl_size[mid]) begin
                        oi = off / tbl_objb[mid];
                        if (oi >= tbl_nobj[mid] || oi >= 256)
                            return mk(rah_pkg::ST_OUTSIDE, mid[rah_pkg::REG_W-1:0],
                                      oi[rah_pkg::OBJ_W-1:0], '0);
                        if (hist[tbl_slot[mid]][oi] != '1)
                            hist[tbl_slot[mid]][oi]++;
                        return mk(rah_pkg::ST_OK, mid[rah_pkg::REG_W-1:0],
                                  oi[rah_pkg::OBJ_W-1:0], hist[tbl_slot[mid]][oi]);
                    end
                    if (c.addr < tbl_start[mid]) hi = mid;
                    else lo = mid + 1;
                end
                return mk(rah_pkg::ST_NOT_FOUND, '0, '0, '0);
            end
            default: begin
                if (c.rreg >= tbl_used || c.robj >= tbl_nobj[c.rreg])
                    return mk(rah_pkg::ST_BAD_INDEX, c.rreg, c.robj, '0);
                return mk(rah_pkg::ST_OK, c.rreg, c.robj, hist[tbl_slot[c.rreg]][c.robj]);
            end
        endcase
    endfunction

    function automatic logic [rah_pkg::ADDR_W-1:0] rand48();
        return rah_pkg::ADDR_W'({$urandom, $urandom});
    endfunction

    function automatic t_cmd cmd(logic [1:0] a, logic [rah_pkg::ADDR_W-1:0] s,
                                 logic [rah_pkg::ADDR_W-1:0] z,
                                 logic [rah_pkg::ADDR_W-1:0] ad,
                                 logic [rah_pkg::REG_W-1:0] r,
                                 logic [rah_pkg::OBJ_W-1:0] o);
        t_cmd c;
        c.action = a;
        c.start  = s;
        c.size   = z;
        c.addr   = ad;
        c.rreg   = r;
        c.robj   = o;
        return c;
    endfunction

    function automatic t_cmd random_cmd(int ins_w);
        t_cmd        c;
        int          pick, e;
        logic [31:0] eff;
        c = cmd(rah_pkg::ACT_INSERT, rand48(), rand48(), rand48(), 4'($urandom),
                8'($urandom));
        eff = (obj_size_reg == '0) ? 32'd1 : 32'(obj_size_reg);
        pick = $urandom_range(0, 99);
        if (pick < ins_w) begin
            c.action = rah_pkg::ACT_INSERT;
            if ($urandom_range(0, 9) < 8) c.start = start_pool[$urandom_range(0, 15)];
            case ($urandom_range(0, 9))
                0:       c.size = rah_pkg::ADDR_W'(eff) << 8;
                1:       c.size = (rah_pkg::ADDR_W'(eff) << 8) + 48'd1;
                2:       c.size = rand48();
                3:       c.size = '0;
                default: c.size = rah_pkg::ADDR_W'($urandom_range(1, eff * 256));
            endcase
        end else if (pick < ins_w + 20) begin
            c.action = rah_pkg::ACT_REMOVE;
            if (tbl_used > 0 && $urandom_range(0, 9) < 7)
                c.start = tbl_start[$urandom_range(0, tbl_used - 1)];
            else if ($urandom_range(0, 1))
                c.start = start_pool[$urandom_range(0, 15)];
        end else if (pick < ins_w + 60) begin
            c.action = rah_pkg::ACT_ACCESS;
            e = (tbl_used > 0) ? $urandom_range(0, tbl_used - 1) : 0;
            if (tbl_used > 0 && tbl_size[e] != 0 && $urandom_range(0, 9) < 8)
                c.addr = tbl_start[e] +
                         rah_pkg::ADDR_W'({$urandom, $urandom} % tbl_size[e]);
            else if ($urandom_range(0, 1))
                c.addr = start_pool[$urandom_range(0, 15)] +
                         rah_pkg::ADDR_W'($urandom_range(0, 4096));
        end else begin
            c.action = rah_pkg::ACT_READ;
            if (tbl_used > 0 && $urandom_range(0, 9) < 7) begin
                e = $urandom_range(0, tbl_used - 1);
                c.rreg = e[rah_pkg::REG_W-1:0];
                c.robj = (tbl_nobj[e] > 0) ? 8'($urandom_range(0, tbl_nobj[e] - 1)) : 8'd0;
            end
        end
        return c;
    endfunction

    task automatic send_word(t_cmd c, bit typed, rah_pkg::t_result res);
        int               gap;
        rah_pkg::t_result p;
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_action       <= c.action;
        i_region_start <= c.start;
        i_region_size  <= c.size;
        i_address      <= c.addr;
        i_read_region  <= c.rreg;
        i_read_object  <= c.robj;
        do @(posedge i_clk); while (o_stall);
        p = histogram_step(c);
        pending_results.push_back(typed ? res : p);
    endtask

    task automatic set_object_size(logic [rah_pkg::OSZ_W-1:0] v);
        i_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (8) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        obj_size_reg = v;
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        rah_pkg::t_result e;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result word with nothing pending");
                    fails++;
                end else begin
                    e = pending_results.pop_front();
                    if (o_status !== e.status) begin
                        $error("status: expected %0d, got %0d", e.status, o_status);
                        fails++;
                    end
                    if (o_region_index !== e.region) begin
                        $error("region_index: expected %0d, got %0d", e.region, o_region_index);
                        fails++;
                    end
                    if (o_object_index !== e.object) begin
                        $error("object_index: expected %0d, got %0d", e.object, o_object_index);
                        fails++;
                    end
                    if (o_count_value !== e.count) begin
                        $error("count_value: expected %0d, got %0d", e.count, o_count_value);
                        fails++;
                    end
                    status_seen[e.status]++;
                end
                results_seen++;
            end
        end
    end

    // receiver: draw a wait per word, hold off for a long stretch once
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                rx_taken++;
                rx_wait = (rx_taken == HOLD_AT) ? HOLD_CYCLES :
                          (quiet ? 0 : $urandom_range(0, 8));
            end
            i_stall <= (rx_wait > 0);
            if (rx_wait > 0) rx_wait--;
        end
    end

    initial begin
        t_row                       rows [$];
        t_row                       r;
        logic [rah_pkg::OSZ_W-1:0]  sizes [PHASES];
        int                         per_phase;
        obj_size_reg = rah_pkg::OBJ_SIZE_RESET;
        tbl_used = 0;
        foreach (slot_busy[i]) slot_busy[i] = 1'b0;
        foreach (tbl_nobj[i]) tbl_nobj[i] = '0;
        sizes = '{rah_pkg::OBJ_SIZE_RESET, 16'd0, 16'hFFFF, 16'd1,
                  16'($urandom_range(2, 65534)), 16'd7};

        r.typed = 1'b1;
        r.cmd = cmd(rah_pkg::ACT_READ, '0, '0, '0, 4'd0, 8'd0);
        r.res = mk(rah_pkg::ST_BAD_INDEX, '0, '0, '0);            rows.push_back(r);
        r.cmd = cmd(rah_pkg::ACT_READ, '0, '0, '0, 4'hF, 8'hFF);
        r.res = mk(rah_pkg::ST_BAD_INDEX, 4'hF, 8'hFF, '0);       rows.push_back(r);
        r.cmd = cmd(rah_pkg::ACT_ACCESS, '0, '0, 48'h0, '0, '0);
        r.res = mk(rah_pkg::ST_NOT_FOUND, '0, '0, '0);            rows.push_back(r);
        r.cmd = cmd(rah_pkg::ACT_REMOVE, 48'h0, '0, '0, '0, '0);
        r.res = mk(rah_pkg::ST_NOT_FOUND, '0, '0, '0);            rows.push_back(r);
        r.cmd = cmd(rah_pkg::ACT_INSERT, 48'h1000, 48'h0, '0, '0, '0);
        r.res = mk(rah_pkg::ST_OK, '0, '0, '0);                   rows.push_back(r);
        r.cmd = cmd(rah_pkg::ACT_INSERT, 48'h0, 48'hFFFF_FFFF_FFFF, '0, '0, '0);
        r.res = mk(rah_pkg::ST_TOO_LARGE, '0, '0, '0);            rows.push_back(r);
        r.cmd = cmd(rah_pkg::ACT_INSERT, 48'h10000, 48'd393217, '0, '0, '0);
        r.res = mk(rah_pkg::ST_TOO_LARGE, '0, '0, '0);            rows.push_back(r);
        r.cmd = cmd(rah_pkg::ACT_INSERT, 48'h10000, 48'd393216, '0, '0, '0);
        r.res = mk(rah_pkg::ST_OK, 4'd1, '0, '0);                 rows.push_back(r);
        r.cmd = cmd(rah_pkg::ACT_ACCESS, '0, '0, 48'h10000, '0, '0);
        r.res = mk(rah_pkg::ST_OK, 4'd1, '0, 32'd1);              rows.push_back(r);
        r.typed = 1'b0;
        r.cmd = cmd(rah_pkg::ACT_ACCESS, '0, '0, 48'h1000, '0, '0);          rows.push_back(r);
        r.cmd = cmd(rah_pkg::ACT_ACCESS, '0, '0, 48'h10000 + 48'd391680, '0, '0);
        rows.push_back(r);
        r.cmd = cmd(rah_pkg::ACT_ACCESS, '0, '0, 48'h10000 + 48'd393215, '0, '0);
        rows.push_back(r);
        r.cmd = cmd(rah_pkg::ACT_ACCESS, '0, '0, 48'h10000 + 48'd393216, '0, '0);
        rows.push_back(r);
        r.cmd = cmd(rah_pkg::ACT_READ, '0, '0, '0, 4'd1, 8'd255);            rows.push_back(r);
        r.cmd = cmd(rah_pkg::ACT_READ, '0, '0, '0, 4'd0, 8'd0);              rows.push_back(r);
        r.cmd = cmd(rah_pkg::ACT_INSERT, 48'h10000, 48'd1, '0, '0, '0);      rows.push_back(r);
        r.cmd = cmd(rah_pkg::ACT_INSERT, 48'hFFFF_FFFF_FFFF, 48'd3000, '0, '0, '0);
        rows.push_back(r);
        r.cmd = cmd(rah_pkg::ACT_ACCESS, '0, '0, 48'h5, '0, '0);             rows.push_back(r);
        r.cmd = cmd(rah_pkg::ACT_ACCESS, '0, '0, 48'hFFFF_FFFF_FFFF, '0, '0); rows.push_back(r);
        r.cmd = cmd(rah_pkg::ACT_ACCESS, '0, '0, 48'h10000, '0, '0);         rows.push_back(r);
        r.cmd = cmd(rah_pkg::ACT_REMOVE, 48'h10000, '0, '0, '0, '0);         rows.push_back(r);
        r.cmd = cmd(rah_pkg::ACT_REMOVE, 48'h1000, '0, '0, '0, '0);          rows.push_back(r);
        r.cmd = cmd(rah_pkg::ACT_READ, '0, '0, '0, 4'd0, 8'd0);              rows.push_back(r);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) send_word(rows[i].cmd, rows[i].typed, rows[i].res);

        per_phase = RAND_ITEMS / PHASES;
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) set_object_size(sizes[ph]);
            foreach (start_pool[i]) start_pool[i] = (i < 10) ? rand48() :
                                                    48'($urandom_range(0, 1 << 20));
            start_pool[14] = '0;
            start_pool[15] = '1;
            for (int n = 0; n < per_phase; n++) begin
                quiet = (n % 120) < 20;
                send_word(random_cmd((ph % 2) ? 40 : 25), 1'b0,
                          mk(rah_pkg::ST_OK, '0, '0, '0));
            end
            quiet = 1'b0;
        end
        i_valid <= 1'b0;

        wait (pending_results.size() == 0);
        repeat (300) @(posedge i_clk);
        $display("%0d result words checked over %0d object size settings", results_seen, PHASES);
        $display("ok %0d, full %0d, too large %0d, not found %0d, outside %0d, bad index %0d",
                 status_seen[rah_pkg::ST_OK], status_seen[rah_pkg::ST_FULL],
                 status_seen[rah_pkg::ST_TOO_LARGE], status_seen[rah_pkg::ST_NOT_FOUND],
                 status_seen[rah_pkg::ST_OUTSIDE], status_seen[rah_pkg::ST_BAD_INDEX]);
        if (fails == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
